@@ hdl/crc16cc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the crc16 frame check: word and register types, reset values,
// register indexes and the one-byte shift-register update.
// No dependencies.

package crc16cc_pkg;

   localparam int unsigned CRC_WIDTH  = 16;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned CSR_WIDTH  = 32;
   localparam int unsigned ADDR_WIDTH = 3;

   localparam logic [CRC_WIDTH-1:0] POLY_RESET = 16'h1021;
   localparam logic [CRC_WIDTH-1:0] INIT_RESET = 16'hFFFF;

   // register index as decoded from paddr[2]
   localparam logic REG_POLYNOMIAL = 1'b0;
   localparam logic REG_INIT_VALUE = 1'b1;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  first_byte;
      logic                  last_byte;
   } item_type;

   typedef struct packed {
      logic [CRC_WIDTH-1:0] polynomial;
      logic [CRC_WIDTH-1:0] init_value;
   } cfg_type;

   // eight shift steps, msb of the data first, no augmentation
   function automatic logic [CRC_WIDTH-1:0] crc_shift_byte(
      input logic [CRC_WIDTH-1:0]  crc,
      input logic [CRC_WIDTH-1:0]  poly,
      input logic [BYTE_WIDTH-1:0] data
   );
      logic [CRC_WIDTH-1:0] r;
      logic                 top;
      r = crc;
      for (int k = BYTE_WIDTH - 1; k >= 0; k--) begin
         top = r[CRC_WIDTH-1];
         r   = {r[CRC_WIDTH-2:0], data[k]};
         if (top) begin
            r = r ^ poly;
         end
      end
      return r;
   endfunction

endpackage

@@ hdl/crc16cc_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the crc16 frame check: byte words in,
// crc words out. Depends on crc16cc_pkg for the field widths.

interface crc16cc_req_if;
   logic                                valid;
   logic                                ready;
   logic [crc16cc_pkg::BYTE_WIDTH-1:0]  data_byte;
   logic                                first_byte;
   logic                                last_byte;

   modport source (output valid, output data_byte, output first_byte, output last_byte,
                   input ready);
   modport sink (input valid, input data_byte, input first_byte, input last_byte,
                 output ready);
endinterface

interface crc16cc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [crc16cc_pkg::CRC_WIDTH-1:0]  crc_result;

   modport source (output valid, output crc_result, input ready);
   modport sink (input valid, input crc_result, output ready);
endinterface

@@ hdl/crc16_ccitt_frame_check.sv @@
`timescale 1ns / 1ps
// Top level of the crc16 frame check. Depends on crc16cc_pkg, the channel
// interfaces in crc16cc_if.sv, crc16cc_csr, crc16cc_in_stage and crc16cc_core.

// Computes a 16-bit crc over byte frames marked by first_byte and last_byte.
// A word with first_byte set is a header: its data is not used and the running
// crc is loaded with init_value. Every other word shifts its byte in msb first
// through the polynomial register (no augmentation). A word with last_byte set
// puts the crc after that word on the result channel; a frame of one header
// word returns init_value. Without a header, bytes continue from whatever the
// crc holds (0xFFFF after reset). Throughput is one byte word per clock while
// no last word waits on a stalled result; the limit is the eight-step xor
// update that feeds the running crc register back. A result passes through
// the input register and then the result register; a stalled result holds
// back only the next last word, other words keep flowing.
// Registers: polynomial at byte address 0 (reset 0x1021), init_value at byte
// address 4 (reset 0xFFFF); write them only while no frame is in flight.

module crc16_ccitt_frame_check (
   input  logic                                clock,
   input  logic                                reset,
   crc16cc_req_if.sink                         req_bus,
   crc16cc_rsp_if.source                       rsp_bus,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [crc16cc_pkg::ADDR_WIDTH-1:0]  paddr,
   input  logic [crc16cc_pkg::CSR_WIDTH-1:0]   pwdata,
   output logic [crc16cc_pkg::CSR_WIDTH-1:0]   prdata,
   output logic                                pready
);

   crc16cc_pkg::cfg_type  cfg;
   crc16cc_pkg::item_type item;
   logic                  item_valid;
   logic                  advance;

   crc16cc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   crc16cc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   crc16cc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_bus    (rsp_bus)
   );

endmodule

@@ hdl/crc16cc_csr.sv @@
`timescale 1ns / 1ps
// APB-style register file for the crc16 frame check: polynomial and init value.
// Depends on crc16cc_pkg.

module crc16cc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [crc16cc_pkg::ADDR_WIDTH-1:0]  paddr,
   input  logic [crc16cc_pkg::CSR_WIDTH-1:0]   pwdata,
   output logic [crc16cc_pkg::CSR_WIDTH-1:0]   prdata,
   output logic                                pready,
   output crc16cc_pkg::cfg_type                cfg
);

   crc16cc_pkg::cfg_type cfg_ff;
   crc16cc_pkg::cfg_type cfg_in;
   logic                 write_en;
   logic                 reg_sel;

   assign pready   = 1'b1;
   assign write_en = psel && penable && pwrite && pready;
   // registers sit on 4-byte steps, low address bits are ignored
   assign reg_sel  = paddr[2];

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_sel)
            crc16cc_pkg::REG_POLYNOMIAL: begin
               cfg_in.polynomial = pwdata[crc16cc_pkg::CRC_WIDTH-1:0];
            end
            crc16cc_pkg::REG_INIT_VALUE: begin
               cfg_in.init_value = pwdata[crc16cc_pkg::CRC_WIDTH-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.polynomial <= crc16cc_pkg::POLY_RESET;
         cfg_ff.init_value <= crc16cc_pkg::INIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         crc16cc_pkg::REG_POLYNOMIAL: begin
            prdata = {{(crc16cc_pkg::CSR_WIDTH - crc16cc_pkg::CRC_WIDTH){1'b0}},
                      cfg_ff.polynomial};
         end
         crc16cc_pkg::REG_INIT_VALUE: begin
            prdata = {{(crc16cc_pkg::CSR_WIDTH - crc16cc_pkg::CRC_WIDTH){1'b0}},
                      cfg_ff.init_value};
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ hdl/crc16cc_in_stage.sv @@
`timescale 1ns / 1ps
// Input register of the crc16 frame check: holds one byte word until the
// update stage takes it. Depends on crc16cc_pkg and crc16cc_req_if.

module crc16cc_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   crc16cc_req_if.sink           req_bus,
   input  logic                  advance,
   output logic                  item_valid,
   output crc16cc_pkg::item_type item
);

   logic                 valid_ff;
   logic                 valid_in;
   crc16cc_pkg::item_type item_ff;
   logic                 load;

   // the register frees up in the same cycle its word moves on
   assign req_bus.ready = !valid_ff || advance;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte  <= req_bus.data_byte;
         item_ff.first_byte <= req_bus.first_byte;
         item_ff.last_byte  <= req_bus.last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

@@ hdl/crc16cc_core.sv @@
`timescale 1ns / 1ps
// Update stage of the crc16 frame check: running crc register, one-byte
// update and the result register. Depends on crc16cc_pkg and crc16cc_rsp_if.

module crc16cc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  crc16cc_pkg::cfg_type  cfg,
   input  logic                  item_valid,
   input  crc16cc_pkg::item_type item,
   output logic                  advance,
   crc16cc_rsp_if.source         rsp_bus
);

   logic [crc16cc_pkg::CRC_WIDTH-1:0] crc_ff;
   logic [crc16cc_pkg::CRC_WIDTH-1:0] crc_in;
   logic [crc16cc_pkg::CRC_WIDTH-1:0] crc_next;
   logic [crc16cc_pkg::CRC_WIDTH-1:0] result_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic                              out_stalled;
   logic                              take;
   logic                              emit;

   assign out_stalled = rsp_valid_ff && !rsp_bus.ready;
   // only a last byte needs room in the result register
   assign advance     = item_valid && !(item.last_byte && out_stalled);
   assign take        = item_valid && advance;
   assign emit        = take && item.last_byte;

   assign crc_next = item.first_byte ? cfg.init_value
                   : crc16cc_pkg::crc_shift_byte(crc_ff, cfg.polynomial, item.data_byte);

   always_comb begin
      crc_in = crc_ff;
      if (take) begin
         crc_in = crc_next;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= crc16cc_pkg::INIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         result_ff <= crc_next;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.crc_result = result_ff;

`ifndef SYNTH
   a_reset_crc: assert property (@(posedge clock)
      reset |=> crc_ff == crc16cc_pkg::INIT_RESET)
      else $error("running crc not at init after reset");

   a_header_loads_init: assert property (@(posedge clock) disable iff (reset)
      (take && item.first_byte) |=> crc_ff == $past(cfg.init_value))
      else $error("header word did not load the init value");

   a_no_drop_on_stall: assert property (@(posedge clock) disable iff (reset)
      (item_valid && item.last_byte && out_stalled) |-> !advance)
      else $error("last word moved on while the result register was full");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      (!emit && !out_stalled) |=> !rsp_valid_ff)
      else $error("result raised without a last word");

   a_result_matches_crc: assert property (@(posedge clock) disable iff (reset)
      emit |=> (rsp_valid_ff && result_ff == crc_ff))
      else $error("emitted result differs from running crc");
`endif

endmodule
